// ===== src/tgc_pkg.sv =====
// ============================================================================
// tgc_pkg: shared types, constants and helpers of the tilt gesture classifier
// Holds the command codes, register indexes, filter window constants and the
// constant divider used by the running-mean filter.
// ============================================================================
package tgc_pkg;

    // Running-mean window length and the width of the slot counter.
    localparam int WINDOW_LEN = 5;
    localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    // Division by WINDOW_LEN is a multiplication by a rounded-up reciprocal.
    // With a 27-bit shift the quotient is exact for magnitudes up to 2**22
    // for every window length from 2 to 16.
    localparam int DIV_SHIFT = 27;
    localparam logic [27:0] DIV_MULT =
        28'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    // Q16 unit directions at 10 and 40 degrees.
    localparam logic signed [17:0] COS10 = 18'sd64540;
    localparam logic signed [17:0] SIN10 = 18'sd11380;
    localparam logic signed [17:0] COS40 = 18'sd50204;
    localparam logic signed [17:0] SIN40 = 18'sd42125;

    // Register reset values.
    localparam logic signed [15:0] PAUSE_ENTER_RESET = 16'sd970;
    localparam logic signed [15:0] PAUSE_EXIT_RESET  = 16'sd900;
    localparam logic [21:0]        JUMP_RATE_RESET   = 22'd100000;

    typedef enum logic [3:0] {
        CMD_NEUTRAL    = 4'd0,
        CMD_PAUSE      = 4'd1,
        CMD_JUMP       = 4'd2,
        CMD_SPECIAL    = 4'd3,
        CMD_SOFT_LEFT  = 4'd4,
        CMD_HARD_LEFT  = 4'd5,
        CMD_SOFT_RIGHT = 4'd6,
        CMD_HARD_RIGHT = 4'd7,
        CMD_ACCEL      = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        REG_PAUSE_ENTER = 2'd0,
        REG_PAUSE_EXIT  = 2'd1,
        REG_JUMP_RATE   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] pause_enter;
        logic signed [15:0] pause_exit;
        logic [21:0]        jump_rate;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] mean_x;
        logic signed [15:0] mean_y;
        logic signed [15:0] mean_z;
        logic signed [22:0] mean_rate;
        logic               button;
    } means_t;

    typedef struct packed {
        logic z_above;
        logic z_below;
        logic rate_high;
        logic button;
        cmd_t steer_cmd;
    } feat_t;

    // Signed division by WINDOW_LEN, truncated toward zero.
    function automatic logic signed [22:0] div_window(input logic signed [22:0] v);
        logic [22:0] mag;
        logic [50:0] prod;
        logic [22:0] quo;
        mag  = v[22] ? (~v + 23'd1) : v;
        prod = {28'd0, mag} * {23'd0, DIV_MULT};
        quo  = prod[DIV_SHIFT +: 23];
        return v[22] ? $signed(~quo + 23'd1) : $signed(quo);
    endfunction

endpackage

// ===== src/tgc_filter.sv =====
// ============================================================================
// tgc_filter: input register and running-mean filter
// Stage one registers each sample already divided by the window length;
// stage two keeps the delay lines and updates the four running means.
// ============================================================================
module tgc_filter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [15:0]  accel_x,
    input  logic signed [15:0]  accel_y,
    input  logic signed [15:0]  accel_z,
    input  logic signed [22:0]  gyro_x,
    input  logic                sample_ok,
    input  logic                button_pressed,
    output logic                out_valid,
    output tgc_pkg::means_t     means
);

    // Stage one: scaled sample.
    logic               s1_valid_reg, s1_ok_reg, s1_btn_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg;
    logic signed [22:0] qr_reg;
    logic signed [15:0] qx_next, qy_next, qz_next;
    logic signed [22:0] qr_next;

    assign qx_next = 16'(tgc_pkg::div_window({{7{accel_x[15]}}, accel_x}));
    assign qy_next = 16'(tgc_pkg::div_window({{7{accel_y[15]}}, accel_y}));
    assign qz_next = 16'(tgc_pkg::div_window({{7{accel_z[15]}}, accel_z}));
    assign qr_next = tgc_pkg::div_window(gyro_x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_ok_reg    <= 1'b0;
            s1_btn_reg   <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s1_ok_reg    <= sample_ok;
            s1_btn_reg   <= button_pressed;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            qz_reg <= qz_next;
            qr_reg <= qr_next;
        end
    end

    // Stage two: delay lines hold the scaled samples, so the oldest term
    // leaves the sum exactly as it entered.
    logic signed [15:0] hist_x_reg [tgc_pkg::WINDOW_LEN];
    logic signed [15:0] hist_y_reg [tgc_pkg::WINDOW_LEN];
    logic signed [15:0] hist_z_reg [tgc_pkg::WINDOW_LEN];
    logic signed [22:0] hist_r_reg [tgc_pkg::WINDOW_LEN];
    logic [tgc_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic signed [15:0] mean_x_reg, mean_y_reg, mean_z_reg;
    logic signed [22:0] mean_r_reg;
    logic signed [15:0] mean_x_next, mean_y_next, mean_z_next;
    logic signed [22:0] mean_r_next;
    logic               s2_valid_reg, s2_btn_reg;
    logic               upd;

    assign upd = en && s1_valid_reg && s1_ok_reg;

    always_comb begin
        mean_x_next = mean_x_reg - hist_x_reg[slot_reg] + qx_reg;
        mean_y_next = mean_y_reg - hist_y_reg[slot_reg] + qy_reg;
        mean_z_next = mean_z_reg - hist_z_reg[slot_reg] + qz_reg;
        mean_r_next = mean_r_reg - hist_r_reg[slot_reg] + qr_reg;
        slot_next   = (slot_reg == tgc_pkg::SLOT_W'(tgc_pkg::WINDOW_LEN - 1)) ?
                      '0 : slot_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tgc_pkg::WINDOW_LEN; i++) begin
                hist_x_reg[i] <= '0;
                hist_y_reg[i] <= '0;
                hist_z_reg[i] <= '0;
                hist_r_reg[i] <= '0;
            end
            slot_reg     <= '0;
            mean_x_reg   <= '0;
            mean_y_reg   <= '0;
            mean_z_reg   <= '0;
            mean_r_reg   <= '0;
            s2_valid_reg <= 1'b0;
            s2_btn_reg   <= 1'b0;
        end else begin
            if (upd) begin
                hist_x_reg[slot_reg] <= qx_reg;
                hist_y_reg[slot_reg] <= qy_reg;
                hist_z_reg[slot_reg] <= qz_reg;
                hist_r_reg[slot_reg] <= qr_reg;
                slot_reg   <= slot_next;
                mean_x_reg <= mean_x_next;
                mean_y_reg <= mean_y_next;
                mean_z_reg <= mean_z_next;
                mean_r_reg <= mean_r_next;
            end
            if (en) begin
                s2_valid_reg <= s1_valid_reg;
                s2_btn_reg   <= s1_btn_reg;
            end
        end
    end

    assign out_valid        = s2_valid_reg;
    assign means.mean_x     = mean_x_reg;
    assign means.mean_y     = mean_y_reg;
    assign means.mean_z     = mean_z_reg;
    assign means.mean_rate  = mean_r_reg;
    assign means.button     = s2_btn_reg;

endmodule

// ===== src/tgc_steer.sv =====
// ============================================================================
// tgc_steer: threshold compares and tilt sector classification
// Compares the means with the configured levels and finds the steering
// sector of the filtered (x, y) vector by cross products with fixed directions.
// ============================================================================
module tgc_steer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  tgc_pkg::means_t  means,
    input  tgc_pkg::cfg_t    cfg,
    output logic             out_valid,
    output tgc_pkg::feat_t   feat
);

    logic signed [15:0] mx, my;
    logic signed [34:0] b10, a10, l40, r40;
    logic signed [23:0] rate_ext, level_ext;
    tgc_pkg::cmd_t      steer_next;
    tgc_pkg::feat_t     feat_reg, feat_next;
    logic               valid_reg;

    assign mx = means.mean_x;
    assign my = means.mean_y;

    // Sign of each cross product tells on which side of a direction the
    // vector lies.
    assign b10 = my * tgc_pkg::COS10 + mx * tgc_pkg::SIN10;
    assign a10 = my * tgc_pkg::COS10 - mx * tgc_pkg::SIN10;
    assign l40 = my * tgc_pkg::COS40 + mx * tgc_pkg::SIN40;
    assign r40 = my * tgc_pkg::COS40 - mx * tgc_pkg::SIN40;

    always_comb begin
        if (mx <= 16'sd0) begin
            if (mx == 16'sd0 && my == 16'sd0) begin
                steer_next = tgc_pkg::CMD_ACCEL;
            end else if (my > 16'sd0 || (my == 16'sd0 && mx < 16'sd0)) begin
                steer_next = tgc_pkg::CMD_HARD_RIGHT;
            end else begin
                steer_next = tgc_pkg::CMD_HARD_LEFT;
            end
        end else if (b10 < 35'sd0) begin
            steer_next = (l40 >= 35'sd0) ? tgc_pkg::CMD_SOFT_LEFT : tgc_pkg::CMD_HARD_LEFT;
        end else if (b10 == 35'sd0) begin
            steer_next = tgc_pkg::CMD_NEUTRAL;
        end else if (a10 > 35'sd0) begin
            steer_next = (r40 <= 35'sd0) ? tgc_pkg::CMD_SOFT_RIGHT : tgc_pkg::CMD_HARD_RIGHT;
        end else if (a10 == 35'sd0) begin
            steer_next = tgc_pkg::CMD_NEUTRAL;
        end else begin
            steer_next = tgc_pkg::CMD_ACCEL;
        end
    end

    assign rate_ext  = {means.mean_rate[22], means.mean_rate};
    assign level_ext = {2'b00, cfg.jump_rate};

    always_comb begin
        feat_next.z_above   = means.mean_z > cfg.pause_enter;
        feat_next.z_below   = means.mean_z < cfg.pause_exit;
        feat_next.rate_high = rate_ext > level_ext;
        feat_next.button    = means.button;
        feat_next.steer_cmd = steer_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            feat_reg <= feat_next;
        end
    end

    assign out_valid = valid_reg;
    assign feat      = feat_reg;

endmodule

// ===== src/tgc_decide.sv =====
// ============================================================================
// tgc_decide: pause and button state, command list and result buffer
// Applies the pause hysteresis, jump and special rules to each item and hands
// out its one to three commands in order, one per cycle while m_ready is high.
// ============================================================================
module tgc_decide (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  tgc_pkg::feat_t  feat,
    input  logic            m_ready,
    output logic            buf_free,
    output logic            m_valid,
    output logic [3:0]      m_command,
    output logic            m_last
);

    logic          paused_reg, paused_next;
    logic          pending_reg, pending_next;
    tgc_pkg::cmd_t buf_reg [3];
    tgc_pkg::cmd_t buf_next [3];
    logic [1:0]    cnt_reg, cnt_next;

    logic          pend, tog_on, tog_off, p_mid, p_new, toggled;
    logic          jump, special, load, pop;
    tgc_pkg::cmd_t main_cmd;

    always_comb begin
        pend    = pending_reg | feat.button;
        tog_on  = feat.z_above && !paused_reg;
        p_mid   = paused_reg | tog_on;
        tog_off = feat.z_below && p_mid;
        p_new   = p_mid && !tog_off;
        toggled = tog_on || tog_off;
        jump    = feat.rate_high && !p_new;
        special = pend && !p_new;

        // Steering only while playing and only when the pause state held;
        // a jump turns any left tilt into neutral.
        priority if (toggled) begin
            main_cmd = tgc_pkg::CMD_PAUSE;
        end else if (p_new) begin
            main_cmd = tgc_pkg::CMD_NEUTRAL;
        end else if (jump && (feat.steer_cmd == tgc_pkg::CMD_SOFT_LEFT ||
                              feat.steer_cmd == tgc_pkg::CMD_HARD_LEFT)) begin
            main_cmd = tgc_pkg::CMD_NEUTRAL;
        end else begin
            main_cmd = feat.steer_cmd;
        end
    end

    assign buf_free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign load     = in_valid && en;
    assign pop      = m_valid && m_ready;

    always_comb begin
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        paused_next  = paused_reg;
        pending_next = pending_reg;
        if (pop) begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
        if (load) begin
            paused_next  = p_new;
            pending_next = pend && !special;
            unique case ({jump, special})
                2'b11: begin
                    buf_next[0] = tgc_pkg::CMD_JUMP;
                    buf_next[1] = tgc_pkg::CMD_SPECIAL;
                    buf_next[2] = main_cmd;
                    cnt_next    = 2'd3;
                end
                2'b10: begin
                    buf_next[0] = tgc_pkg::CMD_JUMP;
                    buf_next[1] = main_cmd;
                    cnt_next    = 2'd2;
                end
                2'b01: begin
                    buf_next[0] = tgc_pkg::CMD_SPECIAL;
                    buf_next[1] = main_cmd;
                    cnt_next    = 2'd2;
                end
                default: begin
                    buf_next[0] = main_cmd;
                    cnt_next    = 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            paused_reg  <= 1'b0;
            pending_reg <= 1'b0;
            cnt_reg     <= 2'd0;
        end else begin
            paused_reg  <= paused_next;
            pending_reg <= pending_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign m_valid   = (cnt_reg != 2'd0);
    assign m_command = buf_reg[0];
    assign m_last    = (cnt_reg == 2'd1);

endmodule

// ===== src/tilt_gesture_command_classifier.sv =====
// ============================================================================
// tilt_gesture_command_classifier: motion samples in, game commands out
// Top level with the register port, the pipeline advance control and the
// filter, classification and decision stages.
// ============================================================================
// Each request on the s_ channel carries one motion sample: three
// accelerations, the x angular rate, a read-ok flag and a button event.
// Each request on the m_ channel carries one command; m_last marks the final
// command of a sample, which yields one to three commands in the order
// jump, special, then the main command, which is always present.
//
// The block is a four-register pipeline: input register with the divide by
// the window length, running-mean update, threshold and sector compares,
// and a three-entry result buffer. With m_ready high the buffer hands out
// one command per cycle and takes the next sample as its last command
// leaves, so single-command samples are accepted back to back; a sample
// with more commands holds the buffer until its last command is taken.
//
// While the receiver holds m_ready low, the buffer keeps its command and the
// earlier stages fill until the compare stage holds a sample the buffer
// cannot take; then every stage freezes and s_ready drops in the same cycle,
// so no sample is dropped or duplicated. Reset (aresetn low, synchronous)
// clears the delay lines, means, pause and button state and result buffer,
// and loads the default levels. The user must see that registers are written
// only while idle; the block has no check for it.
// ============================================================================
module tilt_gesture_command_classifier (
    input  logic               aclk,
    input  logic               aresetn,
    // Sample channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic signed [22:0] s_gyro_x,
    input  logic               s_sample_ok,
    input  logic               s_button_pressed,
    // Command channel.
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_command,
    output logic               m_last,
    // Register port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers. Register i sits at byte address 4*i.
    logic signed [15:0] pause_enter_reg;
    logic signed [15:0] pause_exit_reg;
    logic [21:0]        jump_rate_reg;
    logic               cfg_wr;
    tgc_pkg::reg_idx_t  cfg_idx;
    tgc_pkg::cfg_t      cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = tgc_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pause_enter_reg <= tgc_pkg::PAUSE_ENTER_RESET;
            pause_exit_reg  <= tgc_pkg::PAUSE_EXIT_RESET;
            jump_rate_reg   <= tgc_pkg::JUMP_RATE_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                tgc_pkg::REG_PAUSE_ENTER: pause_enter_reg <= pwdata[15:0];
                tgc_pkg::REG_PAUSE_EXIT:  pause_exit_reg  <= pwdata[15:0];
                tgc_pkg::REG_JUMP_RATE:   jump_rate_reg   <= pwdata[21:0];
                default: begin
                end
            endcase
        end
    end

    // Read data: the signed levels come back sign-extended.
    always_comb begin
        unique case (cfg_idx)
            tgc_pkg::REG_PAUSE_ENTER: prdata = {{16{pause_enter_reg[15]}}, pause_enter_reg};
            tgc_pkg::REG_PAUSE_EXIT:  prdata = {{16{pause_exit_reg[15]}}, pause_exit_reg};
            tgc_pkg::REG_JUMP_RATE:   prdata = {10'd0, jump_rate_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg.pause_enter = pause_enter_reg;
    assign cfg.pause_exit  = pause_exit_reg;
    assign cfg.jump_rate   = jump_rate_reg;

    // Pipeline advance: every stage moves together unless the item in the
    // compare stage has nowhere to go because the result buffer is busy.
    logic            en;
    logic            s2_valid, s3_valid, buf_free;
    tgc_pkg::means_t means;
    tgc_pkg::feat_t  feat;

    assign en      = !s3_valid || buf_free;
    assign s_ready = en;

    tgc_filter u_filter (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (s_valid),
        .accel_x        (s_accel_x),
        .accel_y        (s_accel_y),
        .accel_z        (s_accel_z),
        .gyro_x         (s_gyro_x),
        .sample_ok      (s_sample_ok),
        .button_pressed (s_button_pressed),
        .out_valid      (s2_valid),
        .means          (means)
    );

    tgc_steer u_steer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s2_valid),
        .means     (means),
        .cfg       (cfg),
        .out_valid (s3_valid),
        .feat      (feat)
    );

    tgc_decide u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_valid),
        .feat      (feat),
        .m_ready   (m_ready),
        .buf_free  (buf_free),
        .m_valid   (m_valid),
        .m_command (m_command),
        .m_last    (m_last)
    );

endmodule

// ===== src/tgc_checker.sv =====
// ============================================================================
// tgc_checker: port-level checks of the tilt gesture classifier
// Watches the command and sample channels for ordering and buffering rules of the block.
// ============================================================================
module tgc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [3:0]         m_command,
    input logic               m_last
);

    // A stalled command holds until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_command) && $stable(m_last))
        else $error("stalled command changed");

    // Only the nine command codes appear.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_command <= tgc_pkg::CMD_ACCEL)
        else $error("command code out of range");

    // Jump and special are never the last command of their sample.
    a_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_command == tgc_pkg::CMD_JUMP || m_command == tgc_pkg::CMD_SPECIAL)
        |-> !m_last)
        else $error("jump or special marked as last");

    // The rest of a sample follows straight after a non-final command.
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside the commands of one sample");

    // The sample channel is only held off while commands are waiting.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid)
        else $error("sample stalled with no command waiting");

endmodule

bind tilt_gesture_command_classifier tgc_checker u_checker (.*);
